// ===== hdl/allocation_slot_tracker_core_assert.svh =====
// Assertion macros for the allocation slot tracker.
// They expect signals named clock and reset in the including module.
`ifndef ALLOCATION_SLOT_TRACKER_CORE_ASSERT_SVH
`define ALLOCATION_SLOT_TRACKER_CORE_ASSERT_SVH

`define AST_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

`define AST_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define AST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ast_pkg.sv =====
// Package for the allocation slot tracker: sizes, codes and shared types.
// Used by the channel interfaces, the slot cell and the top level.
package ast_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int ADDR_WIDTH = 32;
   localparam int COUNT_OUT_WIDTH = 5;
   localparam int COUNT_WIDTH = ($clog2(SLOT_COUNT + 1) > COUNT_OUT_WIDTH) ?
                                $clog2(SLOT_COUNT + 1) : COUNT_OUT_WIDTH;

   typedef enum logic [1:0] {
      OP_TRACK   = 2'd0,
      OP_UNTRACK = 2'd1,
      OP_RECLAIM = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_ZERO = 2'd1,
      ST_FULL = 2'd2,
      ST_MISS = 2'd3
   } status_type;

   typedef struct packed {
      logic valid;
      logic done;
   } tok_type;

   typedef struct packed {
      logic placed;
      logic removed;
   } cell_evt_type;

endpackage

// ===== hdl/ast_req_if.sv =====
// Request channel interface for the allocation slot tracker.
// Depends on ast_pkg for the address width.
interface ast_req_if import ast_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [1:0]            req_type;
   logic [ADDR_WIDTH-1:0] address;

   modport source (output valid, req_type, address, input ready);
   modport sink (input valid, req_type, address, output ready);

endinterface

// ===== hdl/ast_rsp_if.sv =====
// Response channel interface for the allocation slot tracker.
// Depends on ast_pkg for the address width.
interface ast_rsp_if import ast_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic [1:0]                 status;
   logic                       freed_valid;
   logic [ADDR_WIDTH-1:0]      freed_address;
   logic [COUNT_OUT_WIDTH-1:0] reclaimed_count;
   logic [COUNT_OUT_WIDTH-1:0] occupied_count;
   logic                       last;

   modport source (output valid, status, freed_valid, freed_address, reclaimed_count,
                   occupied_count, last, input ready);
   modport sink (input valid, status, freed_valid, freed_address, reclaimed_count,
                 occupied_count, last, output ready);

endinterface

// ===== hdl/ast_cell.sv =====
// One slot of the tracker table, with the token stage that walks the chain.
// Depends on ast_pkg for the operation codes and the token type.
module ast_cell import ast_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  op_type                op,
   input  logic [ADDR_WIDTH-1:0] address,
   input  tok_type               tok_in,
   output tok_type               tok_out,
   output cell_evt_type          evt,
   output logic [ADDR_WIDTH-1:0] freed
);

   tok_type               tok_ff;
   logic [ADDR_WIDTH-1:0] slot_ff;
   logic [ADDR_WIDTH-1:0] slot_in;
   logic                  occupied;
   logic                  act;
   logic                  place;
   logic                  remove;

   always_comb begin
      occupied = (slot_ff != '0);
      act      = tok_ff.valid & ~tok_ff.done;
      place    = act & (op == OP_TRACK) & ~occupied;
      remove   = act & occupied &
                 (((op == OP_UNTRACK) & (slot_ff == address)) | (op == OP_RECLAIM));
      slot_in  = place ? address : (remove ? '0 : slot_ff);
      freed    = remove ? slot_ff : '0;
      evt.placed     = place;
      evt.removed    = remove;
      tok_out.valid  = tok_ff.valid;
      tok_out.done   = tok_ff.done | ((place | remove) & (op != OP_RECLAIM));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= '0;
         slot_ff <= '0;
      end else if (step) begin
         tok_ff  <= tok_in;
         slot_ff <= slot_in;
      end
   end

endmodule

// ===== hdl/allocation_slot_tracker_core.sv =====
// Top level of the allocation slot tracker: a chain of slot cells and its sequencer.
// Depends on ast_pkg, ast_req_if, ast_rsp_if, ast_cell and the assertion macros.
//
// The table holds SLOT_COUNT addresses, one per cell, all empty after reset. Each
// request sends a token down the chain of cells, one cell per clock cycle, but the
// token holds while a reclaimed address cannot enter a full output register, and a
// new request is accepted only once the last one has finished. Track fills the first
// empty cell the token meets, untrack empties the first matching cell, and reclaim
// empties every occupied cell, giving one transaction on the response channel per
// freed address, or a single end response if no cell was occupied.
`include "allocation_slot_tracker_core_assert.svh"

module allocation_slot_tracker_core import ast_pkg::*; (
   input logic      clock,
   input logic      reset,
   ast_req_if.sink  req_ch,
   ast_rsp_if.source rsp_ch
);

   tok_type               tok_chain [SLOT_COUNT+1];
   cell_evt_type          evts [SLOT_COUNT];
   logic [ADDR_WIDTH-1:0] freeds [SLOT_COUNT];
   logic [SLOT_COUNT:0]   tok_valid_vec;

   logic                  busy_ff;
   op_type                op_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic                  zero_ff;
   logic [COUNT_WIDTH-1:0] occ_ff;
   logic [COUNT_WIDTH-1:0] rec_ff;
   tok_type               end_ff;

   logic                       rsp_valid_ff;
   status_type                 rsp_status_ff;
   logic                       rsp_fv_ff;
   logic [ADDR_WIDTH-1:0]      rsp_addr_ff;
   logic [COUNT_OUT_WIDTH-1:0] rsp_rec_ff;
   logic [COUNT_OUT_WIDTH-1:0] rsp_occ_ff;
   logic                       rsp_last_ff;

   logic                   accept;
   logic                   out_free;
   logic                   placed_any;
   logic                   removed_any;
   logic [ADDR_WIDTH-1:0]  freed_any;
   logic                   reclaiming;
   logic                   stall;
   logic                   step;
   logic                   emission;
   logic                   need_end;
   logic                   end_load;
   logic                   finish;
   logic                   res_load;
   op_type                 op_in;
   logic [COUNT_WIDTH-1:0] rec_inc;
   logic [COUNT_WIDTH-1:0] occ_dec;
   status_type             end_status;

   assign req_ch.ready = ~busy_ff;
   assign accept       = req_ch.valid & ~busy_ff;
   assign out_free     = ~rsp_valid_ff | rsp_ch.ready;

   assign tok_chain[0].valid = accept;
   assign tok_chain[0].done  = 1'b0;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      ast_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .step    (step),
         .op      (op_ff),
         .address (addr_ff),
         .tok_in  (tok_chain[i]),
         .tok_out (tok_chain[i+1]),
         .evt     (evts[i]),
         .freed   (freeds[i])
      );
      assign tok_valid_vec[i] = tok_chain[i+1].valid;
   end
   assign tok_valid_vec[SLOT_COUNT] = end_ff.valid;

   always_comb begin
      placed_any  = 1'b0;
      removed_any = 1'b0;
      freed_any   = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         placed_any  = placed_any | evts[i].placed;
         removed_any = removed_any | evts[i].removed;
         freed_any   = freed_any | freeds[i];
      end
   end

   always_comb begin
      reclaiming = busy_ff & (op_ff == OP_RECLAIM) & removed_any;
      stall      = reclaiming & ~out_free;
      emission   = reclaiming & out_free;
      step       = accept | (busy_ff & ~end_ff.valid & ~stall);
      need_end   = ~((op_ff == OP_RECLAIM) && (rec_ff != '0));
      end_load   = end_ff.valid & out_free & need_end;
      finish     = end_ff.valid & (out_free | ~need_end);
      res_load   = emission | end_load;
      rec_inc    = rec_ff + 1'b1;
      occ_dec    = occ_ff - 1'b1;
   end

   always_comb begin
      case (op_type'(req_ch.req_type))
         OP_RECLAIM: op_in = OP_RECLAIM;
         OP_NONE:    op_in = OP_NONE;
         default:    op_in = (req_ch.address == '0) ? OP_NONE : op_type'(req_ch.req_type);
      endcase
   end

   always_comb begin
      if (zero_ff) begin
         end_status = ST_ZERO;
      end else begin
         case (op_ff)
            OP_TRACK:   end_status = end_ff.done ? ST_DONE : ST_FULL;
            OP_UNTRACK: end_status = end_ff.done ? ST_DONE : ST_MISS;
            default:    end_status = ST_DONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         end_ff  <= '0;
         occ_ff  <= '0;
         rec_ff  <= '0;
         op_ff   <= OP_NONE;
         zero_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
            op_ff   <= op_in;
            zero_ff <= (req_ch.req_type != OP_RECLAIM) && (req_ch.req_type != OP_NONE) &&
                       (req_ch.address == '0);
            rec_ff  <= '0;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
         if (finish) begin
            end_ff <= '0;
         end else if (step) begin
            end_ff <= tok_chain[SLOT_COUNT];
         end
         if (step & ~accept) begin
            if (placed_any) begin
               occ_ff <= occ_ff + 1'b1;
            end else if (removed_any) begin
               occ_ff <= occ_dec;
            end
         end
         if (emission) begin
            rec_ff <= rec_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= req_ch.address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emission) begin
         rsp_status_ff <= ST_DONE;
         rsp_fv_ff     <= 1'b1;
         rsp_addr_ff   <= freed_any;
         rsp_rec_ff    <= rec_inc[COUNT_OUT_WIDTH-1:0];
         rsp_occ_ff    <= occ_dec[COUNT_OUT_WIDTH-1:0];
         rsp_last_ff   <= (occ_ff == COUNT_WIDTH'(1));
      end else if (end_load) begin
         rsp_status_ff <= end_status;
         rsp_fv_ff     <= 1'b0;
         rsp_addr_ff   <= '0;
         rsp_rec_ff    <= '0;
         rsp_occ_ff    <= occ_ff[COUNT_OUT_WIDTH-1:0];
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.freed_valid     = rsp_fv_ff;
   assign rsp_ch.freed_address   = rsp_addr_ff;
   assign rsp_ch.reclaimed_count = rsp_rec_ff;
   assign rsp_ch.occupied_count  = rsp_occ_ff;
   assign rsp_ch.last            = rsp_last_ff;

   `AST_ASSERT_ALWAYS(a_single_token, $onehot0(tok_valid_vec), "More than one token in the chain.")
   `AST_ASSERT_IMPLY(a_idle_no_token, !busy_ff, tok_valid_vec == '0, "Token present while idle.")
   `AST_ASSERT_ALWAYS(a_occ_range, occ_ff <= COUNT_WIDTH'(SLOT_COUNT), "Occupied count overflow.")
   `AST_ASSERT_IMPLY(a_freed_nonzero, rsp_valid_ff && rsp_fv_ff, rsp_addr_ff != '0,
                     "Reclaimed address is zero.")
   `AST_ASSERT_NEXT(a_finish_idle, finish, !busy_ff, "Block still busy after a request ended.")

endmodule
